// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL, used by station_offset_vote.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SOV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ----- rtl/sov_pkg.sv -----
package sov_pkg;

   localparam int MAX_REPORTS = 16;
   localparam int CW          = $clog2(MAX_REPORTS + 1);
   localparam int IW          = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
   localparam int ID_W        = 16;
   localparam int OFF_W       = 48;
   localparam int TIME_W      = 47;
   localparam int TOL_W       = 32;
   localparam int OUT_CNT_W   = 5;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_VOTE  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_CENTER,
      S_LATCH,
      S_SCAN,
      S_NEXT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [IW-1:0]    rd_addr;
      logic             wr_id_en;
      logic             wr_off_en;
      logic [IW-1:0]    wr_addr;
      logic [ID_W-1:0]  wr_id;
      logic [OFF_W-1:0] wr_off;
   } mem_req_type;

   typedef struct packed {
      logic                 accepted;
      logic                 quorum;
      logic [OFF_W-1:0]     median_off;
      logic [OUT_CNT_W-1:0] cluster_size;
      logic [OUT_CNT_W-1:0] station_count;
   } result_type;

   // |a - b| <= tol, both bounds checked in parallel after one subtract.
   function automatic logic agrees(input logic [OFF_W-1:0] a, input logic [OFF_W-1:0] b,
                                   input logic [TOL_W-1:0] tol);
      logic signed [OFF_W:0] d;
      logic signed [OFF_W:0] t;
      d = $signed({a[OFF_W-1], a}) - $signed({b[OFF_W-1], b});
      t = $signed({{(OFF_W + 1 - TOL_W){1'b0}}, tol});
      return (d <= t) && (d >= -t);
   endfunction

endpackage

// ----- rtl/sov_table.sv -----
module sov_table
   import sov_pkg::*;
(
   input  logic             clock,
   input  mem_req_type      mem_req,
   output logic [ID_W-1:0]  rd_id,
   output logic [OFF_W-1:0] rd_off
);

   logic [ID_W-1:0]  id_mem  [MAX_REPORTS];
   logic [OFF_W-1:0] off_mem [MAX_REPORTS];

   always_ff @(posedge clock) begin
      if (mem_req.wr_id_en) begin
         id_mem[mem_req.wr_addr] <= mem_req.wr_id;
      end
      if (mem_req.wr_off_en) begin
         off_mem[mem_req.wr_addr] <= mem_req.wr_off;
      end
      rd_id  <= id_mem[mem_req.rd_addr];
      rd_off <= off_mem[mem_req.rd_addr];
   end

endmodule

// ----- rtl/sov_ctrl.sv -----
module sov_ctrl
   import sov_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_station_id,
   input  logic [TIME_W-1:0] req_asserted_time_ms,
   input  logic [TIME_W-1:0] req_receive_time_ms,
   input  logic [TOL_W-1:0]  tolerance,
   output mem_req_type       mem_req,
   input  logic [ID_W-1:0]   rd_id,
   input  logic [OFF_W-1:0]  rd_off,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res
);

   state_type        state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic             pend_ff, pend_in;
   logic [IW-1:0]    pidx_ff, pidx_in;
   logic             phase_ff, phase_in;
   logic [ID_W-1:0]  sid_ff, sid_in;
   logic [OFF_W-1:0] roff_ff, roff_in;
   logic [OFF_W-1:0] center_ff, center_in;
   logic             member_ff, member_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [CW-1:0]    lt_ff, lt_in;
   logic [CW-1:0]    le_ff, le_in;
   logic [CW-1:0]    best_n_ff, best_n_in;
   logic [OFF_W-1:0] best_off_ff, best_off_in;
   logic [OFF_W-1:0] lo_ff, lo_in;
   logic [OFF_W-1:0] hi_ff, hi_in;
   logic             accepted_ff, accepted_in;
   logic             vote_ff, vote_in;

   logic             take;
   logic [CW-1:0]    k_hi, k_lo;
   logic signed [OFF_W:0] sum;
   logic signed [OFF_W:0] half;

   assign take  = req_valid && req_ready;
   assign k_hi  = best_n_ff >> 1;
   assign k_lo  = k_hi - 1'b1;
   assign sum   = $signed({lo_ff[OFF_W-1], lo_ff}) + $signed({hi_ff[OFF_W-1], hi_ff});
   // Halve with truncation toward zero.
   assign half  = (sum + $signed({{OFF_W{1'b0}}, sum[OFF_W]})) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      pidx_ff     <= pidx_in;
      phase_ff    <= phase_in;
      sid_ff      <= sid_in;
      roff_ff     <= roff_in;
      center_ff   <= center_in;
      member_ff   <= member_in;
      acc_ff      <= acc_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      best_n_ff   <= best_n_in;
      best_off_ff <= best_off_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      accepted_ff <= accepted_in;
      vote_ff     <= vote_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (req_cmd == CMD_ADD) begin
                  state_in = S_ADD_SCAN;
               end else if (req_cmd == CMD_VOTE && cnt_ff != '0) begin
                  state_in = S_CENTER;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ADD_SCAN: begin
            if ((pend_ff && rd_id == sid_ff) || (!pend_ff && j_ff == cnt_ff)) begin
               state_in = S_DONE;
            end
         end
         S_CENTER: state_in = S_LATCH;
         S_LATCH:  state_in = S_SCAN;
         S_SCAN: begin
            if (!pend_ff && j_ff == cnt_ff) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (phase_ff && i_ff == cnt_ff - 1'b1) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CENTER;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      phase_in    = phase_ff;
      sid_in      = sid_ff;
      roff_in     = roff_ff;
      center_in   = center_ff;
      member_in   = member_ff;
      acc_in      = acc_ff;
      lt_in       = lt_ff;
      le_in       = le_ff;
      best_n_in   = best_n_ff;
      best_off_in = best_off_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      accepted_in = accepted_ff;
      vote_in     = vote_ff;
      mem_req     = '0;
      req_ready   = (state_ff == S_IDLE);
      res_valid   = (state_ff == S_DONE);
      res         = '0;

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               sid_in      = req_station_id;
               roff_in     = {1'b0, req_asserted_time_ms} - {1'b0, req_receive_time_ms};
               accepted_in = 1'b0;
               vote_in     = (req_cmd == CMD_VOTE) && (cnt_ff != '0);
               j_in        = '0;
               i_in        = '0;
               phase_in    = 1'b0;
               best_n_in   = '0;
               if (req_cmd == CMD_CLEAR) begin
                  cnt_in = '0;
               end
            end
         end
         S_ADD_SCAN: begin
            mem_req.wr_off = roff_ff;
            mem_req.wr_id  = sid_ff;
            if (pend_ff && rd_id == sid_ff) begin
               // Known station: overwrite its offset in place.
               mem_req.wr_off_en = 1'b1;
               mem_req.wr_addr   = pidx_ff;
               accepted_in       = 1'b1;
            end else if (j_ff != cnt_ff) begin
               mem_req.rd_addr = j_ff[IW-1:0];
               pidx_in         = j_ff[IW-1:0];
               j_in            = j_ff + 1'b1;
               pend_in         = 1'b1;
            end else if (!pend_ff && cnt_ff < CW'(MAX_REPORTS)) begin
               mem_req.wr_id_en  = 1'b1;
               mem_req.wr_off_en = 1'b1;
               mem_req.wr_addr   = cnt_ff[IW-1:0];
               cnt_in            = cnt_ff + 1'b1;
               accepted_in       = 1'b1;
            end
         end
         S_CENTER: begin
            mem_req.rd_addr = i_ff[IW-1:0];
         end
         S_LATCH: begin
            center_in       = rd_off;
            member_in       = agrees(rd_off, best_off_ff, tolerance);
            mem_req.rd_addr = '0;
            j_in            = CW'(1);
            pend_in         = 1'b1;
            acc_in          = '0;
            lt_in           = '0;
            le_in           = '0;
         end
         S_SCAN: begin
            if (pend_ff) begin
               if (!phase_ff) begin
                  if (agrees(rd_off, center_ff, tolerance)) begin
                     acc_in = acc_ff + 1'b1;
                  end
               end else if (agrees(rd_off, best_off_ff, tolerance)) begin
                  if ($signed(rd_off) < $signed(center_ff)) begin
                     lt_in = lt_ff + 1'b1;
                  end
                  if ($signed(rd_off) <= $signed(center_ff)) begin
                     le_in = le_ff + 1'b1;
                  end
               end
            end
            if (j_ff != cnt_ff) begin
               mem_req.rd_addr = j_ff[IW-1:0];
               j_in            = j_ff + 1'b1;
               pend_in         = 1'b1;
            end
         end
         S_NEXT: begin
            if (!phase_ff) begin
               if (acc_ff > best_n_ff) begin
                  best_n_in   = acc_ff;
                  best_off_in = center_ff;
               end
               if (i_ff == cnt_ff - 1'b1) begin
                  // Winner fixed; start the rank pass for the median.
                  phase_in = 1'b1;
                  i_in     = '0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               if (member_ff && lt_ff <= k_hi && k_hi < le_ff) begin
                  hi_in = center_ff;
               end
               if (member_ff && lt_ff <= k_lo && k_lo < le_ff) begin
                  lo_in = center_ff;
               end
               i_in = i_ff + 1'b1;
            end
         end
         S_DONE: begin
            res.accepted = accepted_ff;
            if (vote_ff) begin
               res.quorum        = (best_n_ff >= CW'(2));
               res.median_off    = best_n_ff[0] ? hi_ff : half[OFF_W-1:0];
               res.cluster_size  = OUT_CNT_W'(best_n_ff);
               res.station_count = OUT_CNT_W'(cnt_ff);
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/station_offset_vote.sv -----
// Clear goes straight to the response; add scans the table for the station before writing;
// vote runs a cluster pass and then a rank pass, each scanning all stations for every center.
// Throughput: one command at a time; vote time is set by the two nested scans
// over the single read port of the offset memory.
// Reset: synchronous, active high; empties the table and zeroes the tolerance.
`include "assert_macros.svh"

module station_offset_vote
   import sov_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [ID_W-1:0]      req_station_id,
   input  logic [TIME_W-1:0]    req_asserted_time_ms,
   input  logic [TIME_W-1:0]    req_receive_time_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic                 rsp_quorum,
   output logic signed [OFF_W-1:0] rsp_median_off,
   output logic [OUT_CNT_W-1:0] rsp_cluster_size,
   output logic [OUT_CNT_W-1:0] rsp_station_count,
   input  logic                 csr_wr_en,
   input  logic [TOL_W-1:0]     csr_wr_data
);

   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   mem_req_type      mem_req;
   logic [ID_W-1:0]  rd_id;
   logic [OFF_W-1:0] rd_off;
   logic             res_valid;
   logic             res_ready;
   result_type       res;

   sov_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_id   (rd_id),
      .rd_off  (rd_off)
   );

   sov_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_station_id       (req_station_id),
      .req_asserted_time_ms (req_asserted_time_ms),
      .req_receive_time_ms  (req_receive_time_ms),
      .tolerance            (tol_ff),
      .mem_req              (mem_req),
      .rd_id                (rd_id),
      .rd_off               (rd_off),
      .res_valid            (res_valid),
      .res_ready            (res_ready),
      .res                  (res)
   );

   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign tol_in       = csr_wr_en ? csr_wr_data : tol_ff;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_ff.accepted;
   assign rsp_quorum        = rsp_ff.quorum;
   assign rsp_median_off    = rsp_ff.median_off;
   assign rsp_cluster_size  = rsp_ff.cluster_size;
   assign rsp_station_count = rsp_ff.station_count;

   `SOV_ASSERT(a_busy_after_transfer, req_valid && req_ready |=> !req_ready,
               "sequencer took a second command")
   `SOV_ASSERT(a_cluster_in_table, rsp_valid |-> rsp_cluster_size <= rsp_station_count,
               "cluster larger than table")
   `SOV_ASSERT(a_add_no_vote_fields,
               rsp_valid && rsp_accepted |-> rsp_station_count == '0 && !rsp_quorum,
               "add result carries vote fields")
   `SOV_ASSERT(a_count_bound, rsp_valid |-> rsp_station_count <= OUT_CNT_W'(MAX_REPORTS),
               "table count beyond capacity")

endmodule
